FILE: sv/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define VSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// property checked in the cycle after its trigger
`define VSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/vsg_pkg.sv
package vsg_pkg;

	localparam int PHASE_BITS  = 24;
	localparam int TABLE_BITS  = 10;
	localparam int TABLE_DEPTH = 1 << TABLE_BITS;
	localparam int STEP_W      = 24;
	localparam int AMP_W       = 14;
	localparam int CFG_IDX_W   = 3;
	localparam int TICK_W      = 32;
	localparam int ECG_W       = 14;
	localparam int PSHAPE_W    = 17;

	typedef longint unsigned u64_t;

	localparam u64_t Q16 = 65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BEAT_STEP   = 3'd0,
		CFG_RESP_STEP   = 3'd1,
		CFG_RESP_AMP    = 3'd2,
		CFG_SLOW_STEP   = 3'd3,
		CFG_DRIFT_STEP  = 3'd4,
		CFG_RIPPLE_STEP = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [STEP_W-1:0] beat_step;
		logic [STEP_W-1:0] resp_step;
		logic [AMP_W-1:0]  resp_amp;
		logic [STEP_W-1:0] slow_step;
		logic [STEP_W-1:0] drift_step;
		logic [STEP_W-1:0] ripple_step;
	} vsg_cfg_t;

	// phases of one tick as handed from the front to the back
	typedef struct packed {
		logic [TABLE_BITS-1:0] beat_idx;
		logic [PHASE_BITS-1:0] resp_ph;
		logic [PHASE_BITS-1:0] slow_ph;
		logic [PHASE_BITS-1:0] drift_ph;
		logic [PHASE_BITS-1:0] ripple_ph;
		logic [TICK_W-1:0]     tick;
	} vsg_item_t;

	typedef logic [ECG_W-1:0]    ecg_tab_t [TABLE_DEPTH];
	typedef logic [PSHAPE_W-1:0] pleth_tab_t [TABLE_DEPTH];

	localparam u64_t EXP_INT_TAB [12] = '{
		65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
	};

	function automatic longint sine_q14(input logic [31:0] p32);
		logic [1:0] quad;
		u64_t z;
		u64_t z2;
		u64_t t;
		longint s;
		quad = p32[31:30];
		z = u64_t'(p32[29:14]);
		if (quad[0])
			z = Q16 - z;
		z2 = (z * z) >> 16;
		t = (u64_t'(4770) * z2) >> 16;
		t = u64_t'(42177) - t;
		t = (t * z2) >> 16;
		t = u64_t'(102944) - t;
		t = (t * z) >> 16;
		s = longint'(t >> 2);
		if (s > 16384)
			s = 16384;
		return quad[1] ? -s : s;
	endfunction

	function automatic u64_t exp_neg_q16(input u64_t t);
		u64_t n;
		u64_t f;
		u64_t q;
		n = t >> 16;
		f = t & u64_t'(16'hFFFF);
		if (n >= 12)
			return 0;
		q = Q16;
		q = Q16 - (f * q) / (6 * Q16);
		q = Q16 - (f * q) / (5 * Q16);
		q = Q16 - (f * q) / (4 * Q16);
		q = Q16 - (f * q) / (3 * Q16);
		q = Q16 - (f * q) / (2 * Q16);
		q = Q16 - (f * q) / Q16;
		return (q * EXP_INT_TAB[n[3:0]]) >> 16;
	endfunction

	function automatic u64_t sq_q16(input longint v);
		u64_t m;
		m = u64_t'(v < 0 ? -v : v);
		return (m * m) >> 16;
	endfunction

	function automatic longint ecg_shape(input u64_t x);
		longint u;
		longint r;
		longint w;
		longint tt;
		u64_t q;
		u64_t s;
		if (x * 100 < 15 * Q16) begin
			u = longint'(x * 100 / 15) - 32768;
			return longint'(exp_neg_q16(8 * sq_q16(u)) * 15 / 100);
		end
		if (x * 100 < 20 * Q16)
			return 0;
		if (x * 100 < 30 * Q16) begin
			q = x * 10 - 2 * Q16;
			if (q * 10 < 2 * Q16)
				return -longint'(q / 2);
			if (q * 10 < 6 * Q16) begin
				r = longint'((q * 10 - 2 * Q16) / 4);
				w = (r - 32768) * 6;
				return longint'(exp_neg_q16(sq_q16(w)) * 12 / 10) - 6553;
			end
			s = (q * 10 - 6 * Q16) / 4;
			return -longint'((Q16 - s) * 8 / 100);
		end
		if (x * 100 < 40 * Q16)
			return 0;
		if (x * 100 < 70 * Q16) begin
			tt = longint'((x * 10 - 4 * Q16) / 3) - 32768;
			return longint'(exp_neg_q16(8 * sq_q16(tt)) * 3 / 10);
		end
		return 0;
	endfunction

	function automatic longint pleth_shape(input u64_t x);
		u64_t u;
		u64_t n;
		longint s;
		if (x * 10 < 3 * Q16) begin
			u = x * 10 / 3;
			return longint'((u * u) >> 16);
		end
		if (x * 10 < 5 * Q16) begin
			n = (x * 10 - 3 * Q16) / 2;
			s = sine_q14(32'(n << 15));
			return longint'(Q16) - (s * 60) / 100;
		end
		return longint'(exp_neg_q16(3 * (2 * x - Q16)) * 85 / 100);
	endfunction

	// ecg level per beat table entry, already offset and clamped
	function automatic ecg_tab_t build_ecg_tab();
		ecg_tab_t tab;
		u64_t x;
		longint e;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			x = u64_t'(i) << (16 - TABLE_BITS);
			e = 8192 + ecg_shape(x) / 10;
			if (e < 0)
				e = 0;
			if (e > 16383)
				e = 16383;
			tab[i] = ECG_W'(e);
		end
		return tab;
	endfunction

	function automatic pleth_tab_t build_pleth_tab();
		pleth_tab_t tab;
		u64_t x;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			x = u64_t'(i) << (16 - TABLE_BITS);
			tab[i] = PSHAPE_W'(pleth_shape(x));
		end
		return tab;
	endfunction

	localparam ecg_tab_t   ECG_TAB   = build_ecg_tab();
	localparam pleth_tab_t PLETH_TAB = build_pleth_tab();

endpackage

FILE: sv/vital_sign_waveform_generator_core.sv
// channel  | handshake                | payload
// in       | in_valid / in_ready      | restart
// out      | out_valid / out_ready    | sample_index, ecg_level ... skin_temp
// cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one tick per clock sustained while out_ready keeps the output moving; a result
// passes through the queue, then the four-multiply sine pipes plus the scaling stage
// a two-entry queue lets input run on while the output is stalled
// arst_n clears phases, tick count, queue and pipeline valids; config goes to defaults
// cfg_ready is always high
module vital_sign_waveform_generator_core
	import vsg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [STEP_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           sample_index,
	output logic [13:0]           ecg_level,
	output logic [13:0]           spo2_level,
	output logic signed [15:0]    resp_level,
	output logic signed [15:0]    pleth_level,
	output logic [13:0]           systolic_level,
	output logic [13:0]           diastolic_level,
	output logic [15:0]           core_temp,
	output logic [15:0]           skin_temp
);

	vsg_cfg_t  cfg_q;
	logic      push, q_full, pop, q_not_empty;
	vsg_item_t wr_item, rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beat_step   <= 24'd20972;
			cfg_q.resp_step   <= 24'd4194;
			cfg_q.resp_amp    <= 14'd8192;
			cfg_q.slow_step   <= 24'd336;
			cfg_q.drift_step  <= 24'd168;
			cfg_q.ripple_step <= 24'd251658;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BEAT_STEP:   cfg_q.beat_step   <= cfg_data;
				CFG_RESP_STEP:   cfg_q.resp_step   <= cfg_data;
				CFG_RESP_AMP:    cfg_q.resp_amp    <= cfg_data[AMP_W-1:0];
				CFG_SLOW_STEP:   cfg_q.slow_step   <= cfg_data;
				CFG_DRIFT_STEP:  cfg_q.drift_step  <= cfg_data;
				CFG_RIPPLE_STEP: cfg_q.ripple_step <= cfg_data;
				default: ;
			endcase
		end
	end

	vsg_front u_front (
		.clk, .arst_n, .cfg(cfg_q), .in_valid, .in_ready, .restart,
		.q_full, .push, .item(wr_item)
	);

	vsg_queue u_queue (
		.clk, .arst_n, .push, .wr_item, .full(q_full), .pop,
		.not_empty(q_not_empty), .rd_item
	);

	vsg_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_not_empty, .q_item(rd_item), .pop,
		.out_valid, .out_ready, .sample_index, .ecg_level, .spo2_level,
		.resp_level, .pleth_level, .systolic_level, .diastolic_level,
		.core_temp, .skin_temp
	);

endmodule

FILE: sv/vsg_front.sv
module vsg_front
	import vsg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  vsg_cfg_t  cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      restart,
	input  logic      q_full,
	output logic      push,
	output vsg_item_t item
);

	logic [PHASE_BITS-1:0] beat_q, resp_q, slow_q, drift_q, ripple_q;
	logic [TICK_W-1:0]     tick_q;
	logic [PHASE_BITS-1:0] beat_c, resp_c, slow_c, drift_c, ripple_c;
	logic [TICK_W-1:0]     tick_c;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// restart clears everything before this tick is sampled
	always_comb begin
		beat_c   = restart ? '0 : beat_q;
		resp_c   = restart ? '0 : resp_q;
		slow_c   = restart ? '0 : slow_q;
		drift_c  = restart ? '0 : drift_q;
		ripple_c = restart ? '0 : ripple_q;
		tick_c   = restart ? '0 : tick_q;
	end

	assign item.beat_idx  = beat_c[PHASE_BITS-1 -: TABLE_BITS];
	assign item.resp_ph   = resp_c;
	assign item.slow_ph   = slow_c;
	assign item.drift_ph  = drift_c;
	assign item.ripple_ph = ripple_c;
	assign item.tick      = tick_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q   <= '0;
			resp_q   <= '0;
			slow_q   <= '0;
			drift_q  <= '0;
			ripple_q <= '0;
			tick_q   <= '0;
		end else if (push) begin
			beat_q   <= beat_c + PHASE_BITS'(cfg.beat_step);
			resp_q   <= resp_c + PHASE_BITS'(cfg.resp_step);
			slow_q   <= slow_c + PHASE_BITS'(cfg.slow_step);
			drift_q  <= drift_c + PHASE_BITS'(cfg.drift_step);
			ripple_q <= ripple_c + PHASE_BITS'(cfg.ripple_step);
			tick_q   <= tick_c + 1'b1;
		end
	end

endmodule

FILE: sv/vsg_queue.sv
module vsg_queue
	import vsg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  vsg_item_t wr_item,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output vsg_item_t rd_item
);

	vsg_item_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

FILE: sv/vsg_sine.sv
module vsg_sine
	import vsg_pkg::*;
(
	input  logic                   clk,
	input  logic                   en,
	input  logic [PHASE_BITS-1:0]  phase,
	output logic signed [15:0]     sine
);

	logic [31:0] p32;
	logic [16:0] z;
	logic [33:0] zz;

	logic [1:0]  quad_s1, quad_s2, quad_s3;
	logic [16:0] z_s1, z_s2, z_s3;
	logic [16:0] z2_s1, z2_s2;
	logic [15:0] u_s2;
	logic [16:0] v_s3;

	logic [29:0] m2;
	logic [32:0] m3;
	logic [33:0] m4;
	logic [16:0] t4;
	logic [14:0] mag;

	assign p32 = 32'(phase) << (32 - PHASE_BITS);
	assign z   = p32[30] ? 17'h10000 - 17'(p32[29:14]) : 17'(p32[29:14]);
	assign zz  = z * z;

	assign m2 = 30'(z2_s1) * 30'd4770;
	assign m3 = 33'(u_s2) * 33'(z2_s2);
	assign m4 = 34'(v_s3) * 34'(z_s3);
	assign t4 = 17'(m4 >> 16);
	// quarter wave peak clamps at one
	assign mag = (t4[16:2] > 15'd16384) ? 15'd16384 : t4[16:2];

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= p32[31:30];
			z_s1    <= z;
			z2_s1   <= 17'(zz >> 16);

			quad_s2 <= quad_s1;
			z_s2    <= z_s1;
			z2_s2   <= z2_s1;
			u_s2    <= 16'd42177 - 16'(m2 >> 16);

			quad_s3 <= quad_s2;
			z_s3    <= z_s2;
			v_s3    <= 17'd102944 - 17'(m3 >> 16);

			sine    <= quad_s3[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

FILE: sv/vsg_back.sv
module vsg_back
	import vsg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  vsg_cfg_t            cfg,
	input  logic                q_not_empty,
	input  vsg_item_t           q_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         sample_index,
	output logic [13:0]         ecg_level,
	output logic [13:0]         spo2_level,
	output logic signed [15:0]  resp_level,
	output logic signed [15:0]  pleth_level,
	output logic [13:0]         systolic_level,
	output logic [13:0]         diastolic_level,
	output logic [15:0]         core_temp,
	output logic [15:0]         skin_temp
);

	logic       adv;
	logic [4:0] vld_q;

	logic [TICK_W-1:0]   tick_s1, tick_s2, tick_s3, tick_s4;
	logic [ECG_W-1:0]    ecg_s1, ecg_s2, ecg_s3, ecg_s4;
	logic [PSHAPE_W-1:0] psh_s1, psh_s2, psh_s3, psh_s4;

	logic signed [15:0] s_resp, s_slow, s_drift, s_rip;
	logic signed [31:0] resp32, slow32, drift32, rip32;
	logic signed [31:0] p_resp, p_spo2, p_sys, p_dia, p_core, p_skin;
	logic signed [31:0] rip2, pleth_sum;
	logic [16:0]        rip_mag;
	logic [29:0]        rip_prod;
	logic [12:0]        rip_q;

	assign adv       = !vld_q[4] || out_ready;
	assign pop       = adv && q_not_empty;
	assign out_valid = vld_q[4];

	vsg_sine u_sin_resp   (.clk, .en(adv), .phase(q_item.resp_ph),   .sine(s_resp));
	vsg_sine u_sin_slow   (.clk, .en(adv), .phase(q_item.slow_ph),   .sine(s_slow));
	vsg_sine u_sin_drift  (.clk, .en(adv), .phase(q_item.drift_ph),  .sine(s_drift));
	vsg_sine u_sin_ripple (.clk, .en(adv), .phase(q_item.ripple_ph), .sine(s_rip));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[3:0], pop};
	end

	always_comb begin
		resp32  = s_resp;
		slow32  = s_slow;
		drift32 = s_drift;
		rip32   = s_rip;
		p_resp  = $signed({18'd0, cfg.resp_amp}) * resp32;
		p_spo2  = slow32 * 32'sd100;
		p_sys   = slow32 * 32'sd500;
		p_dia   = slow32 * 32'sd250;
		p_core  = drift32 * 32'sd200;
		p_skin  = drift32 * 32'sd160;
		// ripple is 2*s/25 toward zero, by reciprocal on the magnitude
		rip2     = rip32 * 32'sd2;
		rip_mag  = rip2 < 0 ? 17'(-rip2) : 17'(rip2);
		rip_prod = 30'(rip_mag) * 30'd5243;
		rip_q    = 13'(rip_prod >> 17);
		pleth_sum = $signed(32'(psh_s4))
			+ (rip2 < 0 ? -$signed(32'(rip_q)) : $signed(32'(rip_q)));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_s1 <= q_item.tick;
			ecg_s1  <= ECG_TAB[q_item.beat_idx];
			psh_s1  <= PLETH_TAB[q_item.beat_idx];
			tick_s2 <= tick_s1;
			ecg_s2  <= ecg_s1;
			psh_s2  <= psh_s1;
			tick_s3 <= tick_s2;
			ecg_s3  <= ecg_s2;
			psh_s3  <= psh_s2;
			tick_s4 <= tick_s3;
			ecg_s4  <= ecg_s3;
			psh_s4  <= psh_s3;

			sample_index    <= tick_s4;
			ecg_level       <= ecg_s4;
			resp_level      <= 16'(p_resp / 32'sd16384);
			pleth_level     <= 16'(pleth_sum / 32'sd4);
			spo2_level      <= 14'(32'sd9750 + p_spo2 / 32'sd16384);
			systolic_level  <= 14'(32'sd12000 + p_sys / 32'sd16384);
			diastolic_level <= 14'(32'sd8000 + p_dia / 32'sd16384);
			core_temp       <= 16'(32'sd37200 + p_core / 32'sd16384);
			skin_temp       <= 16'(32'sd36800 + p_skin / 32'sd16384);
		end
	end

endmodule

FILE: sv/vsg_checker.sv
`include "assert_macros.svh"

module vsg_checker
	import vsg_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [STEP_W-1:0]     cfg_data,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  restart,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [31:0]           sample_index,
	input logic [13:0]           ecg_level,
	input logic [13:0]           spo2_level,
	input logic signed [15:0]    resp_level,
	input logic signed [15:0]    pleth_level,
	input logic [13:0]           systolic_level,
	input logic [13:0]           diastolic_level,
	input logic [15:0]           core_temp,
	input logic [15:0]           skin_temp
);

	// stalled result keeps its timestamp
	`VSG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_index), "stalled result changed")

	`VSG_ASSERT_NOW(a_slow_range, out_valid, spo2_level >= 14'd9600 && spo2_level <= 14'd9900 && systolic_level >= 14'd11500 && systolic_level <= 14'd12500 && diastolic_level >= 14'd7750 && diastolic_level <= 14'd8250, "slow drift level out of range")

	`VSG_ASSERT_NOW(a_temp_range, out_valid, core_temp >= 16'd37000 && core_temp <= 16'd37400 && skin_temp >= 16'd36640 && skin_temp <= 16'd36960, "temperature out of range")

endmodule

bind vital_sign_waveform_generator_core vsg_checker u_vsg_checker (.*);
